/* src/bsp_pkg.sv */
// Shared types, constants and the reciprocal table of the background subtraction block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package bsp_pkg;

  localparam int MAX_PIXELS  = 65536;
  localparam int POS_W       = $clog2(MAX_PIXELS);
  localparam int MAX_WINDOW  = 16;
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int FH_W        = SLOT_W + 1;
  localparam int SUM_W       = 16;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int NUM_W       = SUM_W + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  typedef enum logic [1:0] {
    CFG_MODE      = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_ALPHA     = 2'd3
  } cfg_idx_e;

  // mode code 3 is handled as previous frame
  typedef enum logic [1:0] {
    MODE_PREV = 2'd0,
    MODE_MEAN = 2'd1,
    MODE_EXP  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  // item as it enters the update stage
  typedef struct packed {
    logic [7:0]        pix;
    logic              fend;
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] slot_wr;
    logic [SLOT_W-1:0] slot1;
    logic [SLOT_W-1:0] slotn;
    logic [SLOT_W-1:0] slotn1;
    logic              ev1;
    logic              ev2;
    logic              first;
    logic [FH_W-1:0]   fh;
    logic [1:0]        mode;
    logic [7:0]        thr;
    logic [8:0]        alpha;
    logic [16:0]       b_term;
  } s1_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [7:0]       h1;
    logic [7:0]       expv;
    logic [7:0]       pix;
    logic             fend;
    logic [1:0]       mode;
    logic [7:0]       thr;
    logic [FH_W-1:0]  fh;
    logic             has_res;
  } s2_t;

  typedef struct packed {
    logic       last;
    logic [7:0] bg;
    logic [7:0] fg;
  } res_t;

  // ceil(2^RECIP_SHIFT / d), exact for every numerator the mean can see
  function automatic logic [RECIP_W-1:0] recip(input logic [FH_W-1:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      5'd1:    r = 22'd2097152;
      5'd2:    r = 22'd1048576;
      5'd3:    r = 22'd699051;
      5'd4:    r = 22'd524288;
      5'd5:    r = 22'd419431;
      5'd6:    r = 22'd349526;
      5'd7:    r = 22'd299594;
      5'd8:    r = 22'd262144;
      5'd9:    r = 22'd233017;
      5'd10:   r = 22'd209716;
      5'd11:   r = 22'd190651;
      5'd12:   r = 22'd174763;
      5'd13:   r = 22'd161320;
      5'd14:   r = 22'd149797;
      5'd15:   r = 22'd139811;
      5'd16:   r = 22'd131072;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/bsp_out_fifo.sv */
// Result queue between the pipeline and the output stream.
// Uses bsp_pkg for the result type and the depth.
`timescale 1ns / 1ps

module bsp_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  bsp_pkg::res_t                  data_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output bsp_pkg::res_t                  data_o,
  output logic [bsp_pkg::FIFO_CNT_W-1:0] count_o
);

  bsp_pkg::res_t                  mem_q [bsp_pkg::FIFO_DEPTH];
  logic [bsp_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [bsp_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                           pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)    rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |-> cnt_q < bsp_pkg::FIFO_CNT_W'(bsp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("result queue count wrong after transfer");

endmodule

/* src/bsp_update.sv */
// Per-pixel stores (frame ring, running sum, exponential background) and the
// update stage with write bypass. Depends on bsp_pkg.
`timescale 1ns / 1ps

module bsp_update (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bsp_pkg::POS_W-1:0] rd_addr_i,
  input  logic                      s1_valid_i,
  input  bsp_pkg::s1_t              s1_i,
  output logic                      s2_valid_o,
  output bsp_pkg::s2_t              s2_o
);

  logic [bsp_pkg::MAX_WINDOW-1:0][7:0] hist_mem [bsp_pkg::MAX_PIXELS];
  logic [bsp_pkg::SUM_W-1:0]           sum_mem  [bsp_pkg::MAX_PIXELS];
  logic [7:0]                          exp_mem  [bsp_pkg::MAX_PIXELS];

  logic [bsp_pkg::MAX_WINDOW-1:0][7:0] rd_row_q;
  logic [bsp_pkg::SUM_W-1:0]           rd_sum_q;
  logic [7:0]                          rd_exp_q;

  // last write, for an item that reads the same entry in the next cycle
  logic                        wr_valid_q;
  logic [bsp_pkg::POS_W-1:0]   wr_pos_q;
  logic [bsp_pkg::SLOT_W-1:0]  wr_slot_q;
  logic [7:0]                  wr_pix_q;
  logic [bsp_pkg::SUM_W-1:0]   wr_sum_q;
  logic [7:0]                  wr_exp_q;

  logic                                fwd;
  logic [bsp_pkg::MAX_WINDOW-1:0][7:0] row_c;
  logic [bsp_pkg::SUM_W-1:0]           sum_old, sum_new;
  logic [7:0]                          exp_old, exp_new;
  logic [7:0]                          h1, hn, hn1;
  logic [16:0]                         exp_acc;
  logic                                s2_valid_q;
  bsp_pkg::s2_t                        s2_q;

  assign fwd = wr_valid_q && (wr_pos_q == s1_i.pos);

  always_comb begin
    row_c = rd_row_q;
    if (fwd) row_c[wr_slot_q] = wr_pix_q;
    sum_old = fwd ? wr_sum_q : rd_sum_q;
    exp_old = fwd ? wr_exp_q : rd_exp_q;
    h1  = row_c[s1_i.slot1];
    hn  = row_c[s1_i.slotn];
    hn1 = row_c[s1_i.slotn1];
    exp_acc = 17'(s1_i.alpha * exp_old) + s1_i.b_term;
    if (s1_i.first) begin
      sum_new = bsp_pkg::SUM_W'(s1_i.pix);
      exp_new = s1_i.pix;
    end else begin
      sum_new = sum_old - (s1_i.ev1 ? bsp_pkg::SUM_W'(hn) : '0)
                        - (s1_i.ev2 ? bsp_pkg::SUM_W'(hn1) : '0)
                        + bsp_pkg::SUM_W'(s1_i.pix);
      exp_new = exp_acc[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= hist_mem[rd_addr_i];
    rd_sum_q <= sum_mem[rd_addr_i];
    rd_exp_q <= exp_mem[rd_addr_i];
    if (s1_valid_i) begin
      hist_mem[s1_i.pos][s1_i.slot_wr] <= s1_i.pix;
      sum_mem[s1_i.pos]                <= sum_new;
      exp_mem[s1_i.pos]                <= exp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= s1_valid_i;
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i) begin
      wr_pos_q     <= s1_i.pos;
      wr_slot_q    <= s1_i.slot_wr;
      wr_pix_q     <= s1_i.pix;
      wr_sum_q     <= sum_new;
      wr_exp_q     <= exp_new;
      s2_q.num     <= {1'b0, sum_old} + bsp_pkg::NUM_W'(s1_i.fh >> 1);
      s2_q.h1      <= h1;
      s2_q.expv    <= exp_old;
      s2_q.pix     <= s1_i.pix;
      s2_q.fend    <= s1_i.fend;
      s2_q.mode    <= s1_i.mode;
      s2_q.thr     <= s1_i.thr;
      s2_q.fh      <= s1_i.fh;
      s2_q.has_res <= !s1_i.first;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_i && fwd |-> $past(s1_valid_i))
    else $error("bypass taken without a write in the previous cycle");

endmodule

/* src/bsp_classify.sv */
// Mean by reciprocal multiply, background selection and threshold compare.
// Depends on bsp_pkg.
`timescale 1ns / 1ps

module bsp_classify (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s2_valid_i,
  input  bsp_pkg::s2_t  s2_i,
  output logic          s3_valid_o,
  output logic          push_o,
  output bsp_pkg::res_t res_o
);

  logic [bsp_pkg::PROD_W-1:0] prod;
  logic                       s3_valid_q;
  logic [bsp_pkg::QUOT_W-1:0] quot_q;
  logic [7:0]                 h1_q, expv_q, pix_q, thr_q;
  logic                       fend_q, has_res_q;
  logic [1:0]                 mode_q;
  logic [7:0]                 mean, bg, diff;

  assign prod = s2_i.num * bsp_pkg::recip(s2_i.fh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else         s3_valid_q <= s2_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_i) begin
      quot_q    <= prod[bsp_pkg::PROD_W-1:bsp_pkg::RECIP_SHIFT];
      h1_q      <= s2_i.h1;
      expv_q    <= s2_i.expv;
      pix_q     <= s2_i.pix;
      thr_q     <= s2_i.thr;
      fend_q    <= s2_i.fend;
      has_res_q <= s2_i.has_res;
      mode_q    <= s2_i.mode;
    end
  end

  always_comb begin
    mean = (|quot_q[bsp_pkg::QUOT_W-1:8]) ? 8'd255 : quot_q[7:0];
    unique case (mode_q)
      bsp_pkg::MODE_MEAN: bg = mean;
      bsp_pkg::MODE_EXP:  bg = expv_q;
      default:            bg = h1_q;
    endcase
    diff = (pix_q > bg) ? pix_q - bg : bg - pix_q;
    res_o.fg   = (diff > thr_q) ? 8'd255 : 8'd0;
    res_o.bg   = bg;
    res_o.last = fend_q;
  end

  assign s3_valid_o = s3_valid_q;
  assign push_o     = s3_valid_q && has_res_q;

endmodule

/* src/background_subtraction_per_pixel.sv */
// Background subtraction per pixel: one pixel accepted per clock while the result queue has room.
// A result passes the s1, s2 and s3 registers, is pushed into the result queue and is then offered.
// The per-pixel stores are read and written back with a write bypass, so pixels need not wait.
// Reset clears control and configuration; the frame stores are not cleared,
// since the first frame writes every entry that later frames read.
`timescale 1ns / 1ps

module background_subtraction_per_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] foreground, [15:8] background
  output logic        m_axis_tlast    // last_of_frame
);

  logic [1:0] mode_q;
  logic [7:0] thr_q;
  logic [4:0] window_q;
  logic [8:0] alpha_q;

  logic [bsp_pkg::POS_W-1:0]  pos_q;
  logic [bsp_pkg::FH_W-1:0]   fh_q;
  logic [bsp_pkg::SLOT_W-1:0] rs_q;

  logic [bsp_pkg::FH_W-1:0] k;
  logic [8:0]               alpha_eff;
  logic                     accept;

  logic          s1_valid_q;
  bsp_pkg::s1_t  s1_q;
  logic          s2_valid, s3_valid, push;
  bsp_pkg::s2_t  s2;
  bsp_pkg::res_t res, res_out;
  logic [bsp_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic [bsp_pkg::FIFO_CNT_W:0]   occupancy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bsp_pkg::MODE_PREV;
      thr_q    <= 8'd50;
      window_q <= 5'd10;
      alpha_q  <= 9'd128;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsp_pkg::CFG_MODE:      mode_q   <= cfg_data_i[1:0];
        bsp_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[7:0];
        bsp_pkg::CFG_WINDOW:    window_q <= cfg_data_i[4:0];
        bsp_pkg::CFG_ALPHA:     alpha_q  <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (window_q == '0) k = bsp_pkg::FH_W'(1);
    else if (window_q > bsp_pkg::FH_W'(bsp_pkg::MAX_WINDOW))
      k = bsp_pkg::FH_W'(bsp_pkg::MAX_WINDOW);
    else k = window_q;
    alpha_eff = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
  end

  // everything in flight has a place reserved in the result queue
  assign occupancy = (bsp_pkg::FIFO_CNT_W+1)'(fifo_cnt)
                   + (bsp_pkg::FIFO_CNT_W+1)'(s1_valid_q)
                   + (bsp_pkg::FIFO_CNT_W+1)'(s2_valid)
                   + (bsp_pkg::FIFO_CNT_W+1)'(s3_valid);
  assign s_axis_tready = occupancy < (bsp_pkg::FIFO_CNT_W+1)'(bsp_pkg::FIFO_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      fh_q       <= '0;
      rs_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        if (s_axis_tlast) begin
          pos_q <= '0;
          rs_q  <= rs_q + 1'b1;
          if (fh_q < k)      fh_q <= fh_q + 1'b1;
          else if (fh_q > k) fh_q <= fh_q - 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pix     <= s_axis_tdata;
      s1_q.fend    <= s_axis_tlast;
      s1_q.pos     <= pos_q;
      s1_q.slot_wr <= rs_q;
      s1_q.slot1   <= rs_q - 1'b1;
      s1_q.slotn   <= rs_q - fh_q[bsp_pkg::SLOT_W-1:0];
      s1_q.slotn1  <= rs_q - fh_q[bsp_pkg::SLOT_W-1:0] + 1'b1;
      s1_q.ev1     <= (fh_q >= k);
      s1_q.ev2     <= (fh_q > k);
      s1_q.first   <= (fh_q == '0);
      s1_q.fh      <= fh_q;
      s1_q.mode    <= mode_q;
      s1_q.thr     <= thr_q;
      s1_q.alpha   <= alpha_eff;
      s1_q.b_term  <= 17'((9'd256 - alpha_eff) * s_axis_tdata) + 17'd128;
    end
  end

  bsp_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (pos_q),
    .s1_valid_i (s1_valid_q),
    .s1_i       (s1_q),
    .s2_valid_o (s2_valid),
    .s2_o       (s2)
  );

  bsp_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s2_valid_i (s2_valid),
    .s2_i       (s2),
    .s3_valid_o (s3_valid),
    .push_o     (push),
    .res_o      (res)
  );

  bsp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_out),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata = {res_out.bg, res_out.fg};
  assign m_axis_tlast = res_out.last;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fh_q != '0 |-> ##3 push)
    else $error("pixel after the first frame gave no result");

  a_no_result_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fh_q == '0 |-> ##3 !push)
    else $error("pixel of the first frame gave a result");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fh_q <= bsp_pkg::FH_W'(bsp_pkg::MAX_WINDOW))
    else $error("frame count beyond window");

endmodule
